>>> src/set_assoc_cache_lru_lookup_top_defines.svh
// Assertion macros used by the checker file of the cache lookup block.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_TOP_DEFINES_SVH

// Check that a condition in one cycle implies a condition in the next cycle.
`define SACL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that a condition implies another one in the same cycle.
`define SACL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/sacl_pkg.sv
// Shared types and default constants of the cache lookup block.
package sacl_pkg;

    // Default geometry
    localparam int unsigned ADDR_BITS_DEF   = 16;
    localparam int unsigned SET_BITS_DEF    = 4;
    localparam int unsigned WAYS_DEF        = 4;
    localparam int unsigned OFFSET_BITS_DEF = 4;

    // Fixed result field widths
    localparam int unsigned WAY_OUT_W    = 2;
    localparam int unsigned OFFSET_OUT_W = 4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture address and read the set row
        logic lookup;  // compare, pick a way, write the row back
    } cmd_t;

endpackage

>>> src/sacl_ctrl.sv
// Controller state machine of the cache lookup block.
module sacl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output sacl_pkg::cmd_t     cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    // Next state: each accepted transfer goes from IDLE to LOOKUP and back to IDLE
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == ST_LOOKUP);
            done_reg  <= (state_reg == ST_LOOKUP);
        end
    end

    // Drive commands and status
    assign cmd.load   = start && !busy_reg;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign busy       = busy_reg;
    assign done       = done_reg;

endmodule

>>> src/sacl_dpath.sv
// Datapath of the cache lookup block: tag and age rows, valid bits, way selection.
module sacl_dpath
#(
    parameter int unsigned ADDR_BITS   = sacl_pkg::ADDR_BITS_DEF,
    parameter int unsigned SET_BITS    = sacl_pkg::SET_BITS_DEF,
    parameter int unsigned WAYS        = sacl_pkg::WAYS_DEF,
    parameter int unsigned OFFSET_BITS = sacl_pkg::OFFSET_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sacl_pkg::cmd_t                      cmd,
    input  logic [ADDR_BITS-1:0]                address,
    output logic                                hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]      way_used,
    output logic                                evicted,
    output logic [sacl_pkg::OFFSET_OUT_W-1:0]   block_offset
);

    localparam int unsigned NSETS = 1 << SET_BITS;
    localparam int unsigned TAG_W = ADDR_BITS - SET_BITS - OFFSET_BITS;
    localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned AGE_W = WAY_W;
    localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

    // Set rows: tags and ages in memories, valid bits in flops
    logic [WAYS*TAG_W-1:0] tag_mem [NSETS];
    logic [WAYS*AGE_W-1:0] age_mem [NSETS];
    logic [WAYS-1:0]       valid_reg [NSETS];

    logic [ADDR_BITS-1:0]  addr_reg;
    logic [WAYS*TAG_W-1:0] tag_row_reg;
    logic [WAYS*AGE_W-1:0] age_row_reg;
    logic [WAYS-1:0]       valid_row_reg;

    logic                  hit_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  evicted_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    logic [SET_BITS-1:0]   set_q;
    logic [TAG_W-1:0]      tag_q;
    logic [TAG_W-1:0]      tag_way  [WAYS];
    logic [AGE_W-1:0]      age_way  [WAYS];
    logic [WAYS-1:0]       match;

    logic                  hit_any;
    logic [WAY_W-1:0]      hit_way;
    logic                  free_any;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      old_way;
    logic [WAY_W-1:0]      used;
    logic [AGE_W-1:0]      old_age;

    logic [WAYS*TAG_W-1:0] tag_row_next;
    logic [WAYS*AGE_W-1:0] age_row_next;
    logic [WAYS-1:0]       valid_row_next;

    logic [WAY_W+sacl_pkg::WAY_OUT_W-1:0]          way_wide;
    logic [OFFSET_BITS+sacl_pkg::OFFSET_OUT_W-1:0] offset_wide;

    assign set_q = addr_reg[OFFSET_BITS +: SET_BITS];
    assign tag_q = addr_reg[ADDR_BITS-1 -: TAG_W];

    // Unpack the row; an invalid way reads as age zero
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            tag_way[w] = tag_row_reg[w*TAG_W +: TAG_W];
            age_way[w] = valid_row_reg[w] ? age_row_reg[w*AGE_W +: AGE_W] : '0;
            match[w]   = valid_row_reg[w] && (tag_way[w] == tag_q);
        end
    end

    // Pick the lowest matching way, lowest invalid way and the oldest way
    always_comb
    begin
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        old_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid_row_reg[w])
            begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
            if (age_way[w] == AGE_OLDEST)
            begin
                old_way = WAY_W'(w);
            end
        end
    end

    // Choose the way to use and the rank it leaves behind
    always_comb
    begin
        if (hit_any)
        begin
            used    = hit_way;
            old_age = age_way[hit_way];
        end
        else if (free_any)
        begin
            used    = free_way;
            old_age = AGE_OLDEST;
        end
        else
        begin
            used    = old_way;
            old_age = age_way[old_way];
        end
    end

    // Build the updated row: age younger ways, make the used way most recent
    always_comb
    begin
        tag_row_next   = tag_row_reg;
        age_row_next   = age_row_reg;
        valid_row_next = valid_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == used)
            begin
                age_row_next[w*AGE_W +: AGE_W] = '0;
                valid_row_next[w]              = 1'b1;
                if (!hit_any)
                begin
                    tag_row_next[w*TAG_W +: TAG_W] = tag_q;
                end
            end
            else if (valid_row_reg[w] && (age_way[w] < old_age) &&
                     (age_way[w] < AGE_OLDEST))
            begin
                age_row_next[w*AGE_W +: AGE_W] = age_way[w] + AGE_W'(1);
            end
        end
    end

    // Read the set row on a transfer, write it back after the lookup
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg    <= address;
            tag_row_reg <= tag_mem[address[OFFSET_BITS +: SET_BITS]];
            age_row_reg <= age_mem[address[OFFSET_BITS +: SET_BITS]];
        end
        if (cmd.lookup)
        begin
            tag_mem[set_q] <= tag_row_next;
            age_mem[set_q] <= age_row_next;
            hit_reg        <= hit_any;
            way_reg        <= used;
            evicted_reg    <= !hit_any && !free_any;
            offset_reg     <= addr_reg[OFFSET_BITS-1:0];
        end
    end

    // Valid bits: clear at reset, read and set with the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSETS; s++)
            begin
                valid_reg[s] <= '0;
            end
            valid_row_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                valid_row_reg <= valid_reg[address[OFFSET_BITS +: SET_BITS]];
            end
            if (cmd.lookup)
            begin
                valid_reg[set_q] <= valid_row_next;
            end
        end
    end

    // Fit the result fields to their port widths
    assign way_wide     = {{sacl_pkg::WAY_OUT_W{1'b0}}, way_reg};
    assign offset_wide  = {{sacl_pkg::OFFSET_OUT_W{1'b0}}, offset_reg};
    assign hit          = hit_reg;
    assign way_used     = way_wide[sacl_pkg::WAY_OUT_W-1:0];
    assign evicted      = evicted_reg;
    assign block_offset = offset_wide[sacl_pkg::OFFSET_OUT_W-1:0];

endmodule

>>> src/set_assoc_cache_lru_lookup_top.sv
// Flow: a taken transfer registers the address and the set row; the lookup state
// then registers the result, which shows with done high for one cycle.
// A new address is taken only while busy is low, after the read, compare and
// write-back of the last set row. busy is high during the lookup cycle.
// The result port cannot be stalled. Reset (rst_n low, asynchronous) clears all
// valid bits and the controller at once.
// Top level of the set-associative tag store with LRU replacement.
module set_assoc_cache_lru_lookup_top
#(
    parameter int unsigned ADDR_BITS   = sacl_pkg::ADDR_BITS_DEF,
    parameter int unsigned SET_BITS    = sacl_pkg::SET_BITS_DEF,
    parameter int unsigned WAYS        = sacl_pkg::WAYS_DEF,
    parameter int unsigned OFFSET_BITS = sacl_pkg::OFFSET_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ADDR_BITS-1:0]                address,
    output logic                                done,
    output logic                                hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]      way_used,
    output logic                                evicted,
    output logic [sacl_pkg::OFFSET_OUT_W-1:0]   block_offset
);

    sacl_pkg::cmd_t cmd;

    // Sequence each transfer
    sacl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Look up and update the set
    sacl_dpath
    #(
        .ADDR_BITS   (ADDR_BITS),
        .SET_BITS    (SET_BITS),
        .WAYS        (WAYS),
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .address      (address),
        .hit          (hit),
        .way_used     (way_used),
        .evicted      (evicted),
        .block_offset (block_offset)
    );

endmodule

>>> src/sacl_checker.sv
// Port-level checker of the cache lookup block and its bind to the top level.
`include "set_assoc_cache_lru_lookup_top_defines.svh"

module sacl_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic hit,
    input logic evicted
);

    // A taken transfer makes the block busy for exactly one cycle
    `SACL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "no busy after transfer")
    `SACL_ASSERT_NEXT(a_busy_one, clk, rst_n, busy, !busy, "busy held longer than one cycle")

    // Every result comes from an earlier taken transfer
    `SACL_ASSERT_SAME(a_done_src, clk, rst_n, done, $past(start && !busy, 2), "orphan result")

    // A hit never evicts
    `SACL_ASSERT_SAME(a_hit_evict, clk, rst_n, done && hit, !evicted, "hit reported an eviction")

endmodule

bind set_assoc_cache_lru_lookup_top sacl_checker u_sacl_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .hit     (hit),
    .evicted (evicted)
);
